// ===== sv/qvr_pkg.sv =====
// qvr_pkg: shared constants for the quaternion vector rotation pipeline.
// No dependencies.
package qvr_pkg;

    // Vector components carried per item (x, y, z)
    localparam int LANES = 3;

    // Index of each cross/dot product term formed in the first stage
    localparam int P_XVX = 0;
    localparam int P_YVY = 1;
    localparam int P_ZVZ = 2;
    localparam int P_YVZ = 3;
    localparam int P_ZVY = 4;
    localparam int P_ZVX = 5;
    localparam int P_XVZ = 6;
    localparam int P_XVY = 7;
    localparam int P_YVX = 8;
    localparam int NPROD = 9;

endpackage

// ===== sv/quaternion_vector_rotate.sv =====
// quaternion_vector_rotate: rotates a Q16.16 vector by a Q1.14 quaternion.
// Depends on qvr_pkg.
//
// Usage
//   Input word: quaternion (s_quat_*) and vector (s_vec_*), valid/ready.
//   Output word: rotated vector (m_rot_*) and m_zero_norm, valid/ready.
//   Result is the vector part of q*(0,v)*q^-1, rounded to nearest (ties away
//   from zero) and saturated to the signed VEC_WIDTH range. A zero quaternion
//   returns a zero vector with m_zero_norm set.
// Timing
//   One word is accepted per cycle while m_ready does not hold the output;
//   the restoring divider resolves one quotient bit per pipeline stage for
//   each lane.
// Reset
//   aresetn (synchronous, active low) clears all stage valid bits; data
//   registers are not reset.
// Backpressure
//   When the output word is held by m_ready low, the whole pipeline freezes
//   and s_ready drops; bubbles hold their place too, so no word is lost or
//   repeated.
module quaternion_vector_rotate #(
    parameter int QUAT_WIDTH = 16,
    parameter int VEC_WIDTH  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [QUAT_WIDTH-1:0]  s_quat_w,
    input  logic signed [QUAT_WIDTH-1:0]  s_quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  s_quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  s_quat_z,
    input  logic signed [VEC_WIDTH-1:0]   s_vec_x,
    input  logic signed [VEC_WIDTH-1:0]   s_vec_y,
    input  logic signed [VEC_WIDTH-1:0]   s_vec_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VEC_WIDTH-1:0]   m_rot_x,
    output logic signed [VEC_WIDTH-1:0]   m_rot_y,
    output logic signed [VEC_WIDTH-1:0]   m_rot_z,
    output logic                          m_zero_norm
);
    import qvr_pkg::*;

    localparam int QW   = QUAT_WIDTH;
    localparam int VW   = VEC_WIDTH;
    localparam int PW   = 2 * QW;            // square of a component
    localparam int QVW  = QW + VW;           // component times vector
    localparam int NW   = 2 * QW + 1;        // squared norm, unsigned
    localparam int SW   = 2 * QW + 2;        // w*w - u.u
    localparam int DW   = QVW + 2;           // u.v
    localparam int CW   = QVW + 1;           // u x v
    localparam int TW   = 2 * QW + VW + 3;   // one numerator term
    localparam int NUMW = TW + 2;            // numerator
    localparam int RW   = NW;                // divider remainder
    localparam logic [VW:0] LIM = (VW+1)'(1) << (VW - 1);

    logic adv;

    // Stage 1: products
    logic                  v1_reg;
    logic signed [PW-1:0]  sq1_reg [4];
    logic signed [QVW-1:0] pr1_reg [NPROD];
    logic signed [QW-1:0]  w1_reg;
    logic signed [QW-1:0]  u1_reg  [LANES];
    logic signed [VW-1:0]  vv1_reg [LANES];

    // Stage 2: norm, scalar, dot, cross
    logic                  v2_reg;
    logic [NW-1:0]         n2_reg;
    logic signed [SW-1:0]  s2_reg;
    logic signed [DW-1:0]  d2_reg;
    logic signed [CW-1:0]  c2_reg  [LANES];
    logic signed [QW-1:0]  w2_reg;
    logic signed [QW-1:0]  u2_reg  [LANES];
    logic signed [VW-1:0]  vv2_reg [LANES];

    // Stage 3: numerator terms
    logic                  v3_reg;
    logic [NW-1:0]         n3_reg;
    logic signed [TW-1:0]  ta3_reg [LANES];
    logic signed [TW-1:0]  tb3_reg [LANES];
    logic signed [TW-1:0]  tc3_reg [LANES];

    // Stage 4: numerator sums
    logic                  v4_reg;
    logic [NW-1:0]         n4_reg;
    logic                  z4_reg;
    logic signed [NUMW-1:0] num4_reg [LANES];

    // Divider stages: index 0 is the magnitude stage, index k has k bits done
    logic                  vd_reg  [VW+1];
    logic [NW-1:0]         nd_reg  [VW+1];
    logic                  zd_reg  [VW+1];
    logic [RW-1:0]         rem_reg [VW+1][LANES];
    logic [VW-1:0]         q_reg   [VW+1][LANES];
    logic [VW-1:0]         lo_reg  [VW+1][LANES];
    logic                  neg_reg [VW+1][LANES];
    logic                  ovf_reg [VW+1][LANES];

    // Output stage
    logic                  vo_reg;
    logic signed [VW-1:0]  rot_reg [LANES];
    logic                  zo_reg;

    // Freeze the whole pipe while the output word waits
    assign adv     = !vo_reg || m_ready;
    assign s_ready = adv;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k <= VW; k++) begin
                vd_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            vd_reg[0] <= v4_reg;
            for (int k = 1; k <= VW; k++) begin
                vd_reg[k] <= vd_reg[k-1];
            end
            vo_reg <= vd_reg[VW];
        end
    end

    // Stage 1: squares and component-by-vector products
    logic signed [QW-1:0]  uin [LANES];
    logic signed [VW-1:0]  vin [LANES];
    logic signed [PW-1:0]  sq_next [4];
    logic signed [QVW-1:0] pr_next [NPROD];

    always_comb begin
        uin[0] = s_quat_x;
        uin[1] = s_quat_y;
        uin[2] = s_quat_z;
        vin[0] = s_vec_x;
        vin[1] = s_vec_y;
        vin[2] = s_vec_z;
        sq_next[0] = s_quat_w * s_quat_w;
        sq_next[1] = s_quat_x * s_quat_x;
        sq_next[2] = s_quat_y * s_quat_y;
        sq_next[3] = s_quat_z * s_quat_z;
        pr_next[P_XVX] = s_quat_x * s_vec_x;
        pr_next[P_YVY] = s_quat_y * s_vec_y;
        pr_next[P_ZVZ] = s_quat_z * s_vec_z;
        pr_next[P_YVZ] = s_quat_y * s_vec_z;
        pr_next[P_ZVY] = s_quat_z * s_vec_y;
        pr_next[P_ZVX] = s_quat_z * s_vec_x;
        pr_next[P_XVZ] = s_quat_x * s_vec_z;
        pr_next[P_XVY] = s_quat_x * s_vec_y;
        pr_next[P_YVX] = s_quat_y * s_vec_x;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq1_reg <= sq_next;
            pr1_reg <= pr_next;
            w1_reg  <= s_quat_w;
            u1_reg  <= uin;
            vv1_reg <= vin;
        end
    end

    // Stage 2: norm, scalar factor, dot and cross products
    logic [NW-1:0]        n2_next;
    logic signed [SW-1:0] s2_next;
    logic signed [DW-1:0] d2_next;
    logic signed [CW-1:0] c2_next [LANES];

    always_comb begin
        n2_next = NW'($unsigned(sq1_reg[0])) + NW'($unsigned(sq1_reg[1]))
                + NW'($unsigned(sq1_reg[2])) + NW'($unsigned(sq1_reg[3]));
        s2_next = SW'(sq1_reg[0]) - SW'(sq1_reg[1]) - SW'(sq1_reg[2]) - SW'(sq1_reg[3]);
        d2_next = DW'(pr1_reg[P_XVX]) + DW'(pr1_reg[P_YVY]) + DW'(pr1_reg[P_ZVZ]);
        c2_next[0] = CW'(pr1_reg[P_YVZ]) - CW'(pr1_reg[P_ZVY]);
        c2_next[1] = CW'(pr1_reg[P_ZVX]) - CW'(pr1_reg[P_XVZ]);
        c2_next[2] = CW'(pr1_reg[P_XVY]) - CW'(pr1_reg[P_YVX]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n2_reg  <= n2_next;
            s2_reg  <= s2_next;
            d2_reg  <= d2_next;
            c2_reg  <= c2_next;
            w2_reg  <= w1_reg;
            u2_reg  <= u1_reg;
            vv2_reg <= vv1_reg;
        end
    end

    // Stage 3: the three numerator terms per lane
    logic signed [DW:0]   twod;
    logic signed [QW:0]   twow;
    logic signed [TW-1:0] ta_next [LANES];
    logic signed [TW-1:0] tb_next [LANES];
    logic signed [TW-1:0] tc_next [LANES];

    always_comb begin
        twod = $signed({d2_reg, 1'b0});
        twow = $signed({w2_reg, 1'b0});
        for (int k = 0; k < LANES; k++) begin
            ta_next[k] = s2_reg * vv2_reg[k];
            tb_next[k] = twod * u2_reg[k];
            tc_next[k] = twow * c2_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n3_reg  <= n2_reg;
            ta3_reg <= ta_next;
            tb3_reg <= tb_next;
            tc3_reg <= tc_next;
        end
    end

    // Stage 4: sum the terms, flag a zero norm
    logic signed [NUMW-1:0] num_next [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            num_next[k] = NUMW'(ta3_reg[k]) + NUMW'(tb3_reg[k]) + NUMW'(tc3_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n4_reg   <= n3_reg;
            z4_reg   <= (n3_reg == '0);
            num4_reg <= num_next;
        end
    end

    // Divider entry: magnitude, sign, overflow and first partial remainder
    logic [NUMW-1:0] mag      [LANES];
    logic [NUMW-1:0] nshift;
    logic            neg_next [LANES];
    logic            ovf_next [LANES];

    always_comb begin
        nshift = NUMW'({n4_reg, {VW{1'b0}}});
        for (int k = 0; k < LANES; k++) begin
            neg_next[k] = num4_reg[k][NUMW-1];
            mag[k]      = neg_next[k] ? NUMW'(-num4_reg[k]) : NUMW'(num4_reg[k]);
            ovf_next[k] = (mag[k] >= nshift);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nd_reg[0] <= n4_reg;
            zd_reg[0] <= z4_reg;
            for (int k = 0; k < LANES; k++) begin
                rem_reg[0][k] <= mag[k][VW +: RW];
                lo_reg[0][k]  <= mag[k][VW-1:0];
                q_reg[0][k]   <= '0;
                neg_reg[0][k] <= neg_next[k];
                ovf_reg[0][k] <= ovf_next[k];
            end
        end
    end

    // Restoring divider: one quotient bit per stage, MSB first
    for (genvar j = 0; j < VW; j++) begin : g_div
        localparam int B = VW - 1 - j;
        logic [RW:0]   trial [LANES];
        logic          ge    [LANES];
        logic [RW-1:0] rem_next [LANES];
        logic [VW-1:0] q_next   [LANES];

        always_comb begin
            for (int k = 0; k < LANES; k++) begin
                trial[k]    = {rem_reg[j][k], lo_reg[j][k][B]};
                ge[k]       = (trial[k] >= {1'b0, nd_reg[j]});
                rem_next[k] = ge[k] ? RW'(trial[k] - {1'b0, nd_reg[j]}) : RW'(trial[k]);
                q_next[k]   = q_reg[j][k];
                q_next[k][B] = ge[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                nd_reg[j+1]  <= nd_reg[j];
                zd_reg[j+1]  <= zd_reg[j];
                rem_reg[j+1] <= rem_next;
                q_reg[j+1]   <= q_next;
                lo_reg[j+1]  <= lo_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    // Output: round half away from zero, saturate, apply sign
    logic                 rnd     [LANES];
    logic [VW:0]          qr      [LANES];
    logic signed [VW-1:0] rot_next [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            rnd[k] = ({rem_reg[VW][k], 1'b0} >= {1'b0, nd_reg[VW]});
            qr[k]  = (VW+1)'(q_reg[VW][k]) + (VW+1)'(rnd[k]);
            if (zd_reg[VW]) begin
                rot_next[k] = '0;
            end else if (!neg_reg[VW][k]) begin
                if (ovf_reg[VW][k] || qr[k] > LIM - 1'b1) begin
                    rot_next[k] = VW'(LIM - 1'b1);
                end else begin
                    rot_next[k] = VW'(qr[k]);
                end
            end else begin
                if (ovf_reg[VW][k] || qr[k] > LIM) begin
                    rot_next[k] = VW'(LIM);
                end else begin
                    rot_next[k] = VW'(-qr[k]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rot_reg <= rot_next;
            zo_reg  <= zd_reg[VW];
        end
    end

    assign m_valid     = vo_reg;
    assign m_rot_x     = rot_reg[0];
    assign m_rot_y     = rot_reg[1];
    assign m_rot_z     = rot_reg[2];
    assign m_zero_norm = zo_reg;

endmodule

// ===== tb/sv/tb_quaternion_vector_rotate.sv =====
// tb_quaternion_vector_rotate: randomized stream test of the quaternion vector rotation
// pipeline, with a scoreboard that predicts every rotated vector in exact integer math.
// Depends on quaternion_vector_rotate (and qvr_pkg through it).

class rotation_scoreboard;
    typedef struct {
        logic signed [31:0] x, y, z;
        logic               zn;
    } rot_word_t;

    rot_word_t pending[$];
    int        errors;

    function new();
        errors = 0;
    endfunction

    // round(num / den) ties away from zero, saturate to 32 bits
    function logic signed [31:0] div_round_sat(logic signed [127:0] num,
                                               logic signed [127:0] den);
        logic               neg;
        logic [127:0]       mag;
        logic [127:0]       quo;
        logic [127:0]       rem;
        neg = num[127];
        mag = neg ? -num : num;
        quo = mag / den;
        rem = mag % den;
        if ((rem << 1) >= den) quo = quo + 1;
        if (!neg) begin
            if (quo > 128'h7fffffff) return 32'sh7fffffff;
            return quo[31:0];
        end
        if (quo > 128'h80000000) return 32'sh80000000;
        return -quo[31:0];
    endfunction

    // predict the rotated vector for one accepted input word
    function void note_input(logic signed [15:0] qw, logic signed [15:0] qx,
                             logic signed [15:0] qy, logic signed [15:0] qz,
                             logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz);
        logic signed [127:0] w, x, y, z, ax, ay, az, n, s, d, cx, cy, cz;
        rot_word_t           r;
        w = qw; x = qx; y = qy; z = qz; ax = vx; ay = vy; az = vz;
        n = w*w + x*x + y*y + z*z;
        if (n == 0) begin
            r = '{0, 0, 0, 1'b1};
        end else begin
            s  = w*w - x*x - y*y - z*z;
            d  = x*ax + y*ay + z*az;
            cx = y*az - z*ay;
            cy = z*ax - x*az;
            cz = x*ay - y*ax;
            r.x  = div_round_sat(s*ax + 2*d*x + 2*w*cx, n);
            r.y  = div_round_sat(s*ay + 2*d*y + 2*w*cy, n);
            r.z  = div_round_sat(s*az + 2*d*z + 2*w*cz, n);
            r.zn = 1'b0;
        end
        pending.push_back(r);
    endfunction

    // compare one result word with the oldest prediction
    function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic zn);
        rot_word_t e;
        if (pending.size() == 0) begin
            $error("unexpected result word");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (x !== e.x) begin $error("rot_x exp %0d got %0d", e.x, x); errors++; end
        if (y !== e.y) begin $error("rot_y exp %0d got %0d", e.y, y); errors++; end
        if (z !== e.z) begin $error("rot_z exp %0d got %0d", e.z, z); errors++; end
        if (zn !== e.zn) begin $error("zero_norm exp %0b got %0b", e.zn, zn); errors++; end
    endfunction
endclass

module tb_quaternion_vector_rotate;
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_quat_w, s_quat_x, s_quat_y, s_quat_z;
    logic signed [31:0] s_vec_x, s_vec_y, s_vec_z;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_rot_x, m_rot_y, m_rot_z;
    logic               m_zero_norm;

    rotation_scoreboard board;

    quaternion_vector_rotate dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

    // hold one input word until accepted, after the given gap; starts and ends
    // at a falling edge and leaves valid high for a following word
    task automatic send_word(logic signed [15:0] qw, logic signed [15:0] qx,
                             logic signed [15:0] qy, logic signed [15:0] qz,
                             logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_quat_w <= qw; s_quat_x <= qx; s_quat_y <= qy; s_quat_z <= qz;
        s_vec_x  <= vx; s_vec_y  <= vy; s_vec_z  <= vz;
        do @(posedge aclk); while (!s_ready);
        board.note_input(qw, qx, qy, qz, vx, vy, vz);
        @(negedge aclk);
    endtask

    // drop valid and wait until every predicted word has come back
    task automatic drain_all();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic signed [15:0] pick_quat();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_vec();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($urandom_range(0, 2000)) - 32'sd1000;
            default: return 32'($urandom);
        endcase
    endfunction

    // drain results with random stalls
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
            end
            @(posedge aclk);
            if (m_valid && m_ready)
                board.check_result(m_rot_x, m_rot_y, m_rot_z, m_zero_norm);
        end
    end

    initial begin
        int gap;
        board    = new();
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        {s_quat_w, s_quat_x, s_quat_y, s_quat_z} = '0;
        {s_vec_x, s_vec_y, s_vec_z} = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: identity, zero quaternion, extremes, half turns
        send_word(16'sd16384, 0, 0, 0, 32'sd65536, -32'sd65536, 32'sd123, 0);
        send_word(0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sd1, 0);
        send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
        send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        send_word(0, 16'sd16384, 0, 0, 32'sd1, 32'sd65536, 32'sd7, 1);
        send_word(0, 0, 16'sd16384, 0, 32'sh7fffffff, 32'sd3, 32'sh80000000, 0);
        send_word(0, 0, 0, 16'sd16384, 32'sd5, 32'sh80000000, 32'sd2, 2);
        send_word(16'sd11585, 0, 0, 16'sd11585, 32'sd65536, 0, 0, 0);
        send_word(16'sd1, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, -32'sd1, 0);
        send_word(0, 16'sh8000, 16'sh7fff, 0, 32'sh80000000, 32'sh7fffffff, 0, 0);
        send_word(16'sh8000, 0, 0, 0, -32'sd1, 32'sd1, 32'sd0, 0);
        send_word(0, 0, 0, -16'sd1, 32'sd3, 32'sd3, 32'sd3, 0);

        // random stream; stretches without gaps, one full drain midway
        for (int i = 0; i < 900; i++) begin
            gap = ((i / 100) % 2 == 0) ? 0 : $urandom_range(0, 8);
            if (i == 450) begin
                drain_all();
            end
            if ($urandom_range(0, 40) == 0)
                send_word(0, 0, 0, 0, pick_vec(), pick_vec(), pick_vec(), gap);
            else
                send_word(pick_quat(), pick_quat(), pick_quat(), pick_quat(),
                          pick_vec(), pick_vec(), pick_vec(), gap);
        end

        drain_all();
        repeat (60) @(posedge aclk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/qvr_pkg.sv
sv/quaternion_vector_rotate.sv
tb/sv/tb_quaternion_vector_rotate.sv
